@@ rtl/sfd_pkg.sv @@
// shared constants and types for the serial-bus frame decoder
// no dependencies; imported by every module of the block
package sfd_pkg;

    localparam int FRAME_LENGTH  = 25;
    localparam int STORE_DEPTH   = FRAME_LENGTH - 1;
    localparam int POS_WIDTH     = 5;
    localparam int NUM_CHANNELS  = 16;
    localparam int CHAN_WIDTH    = 4;
    localparam int RAW_WIDTH     = 11;
    localparam int PAYLOAD_BYTES = 22;
    localparam int PAYLOAD_WIDTH = PAYLOAD_BYTES * 8;
    localparam int FLAGS_INDEX   = 23;
    localparam int VALUE_WIDTH   = 12;
    localparam int CALC_WIDTH    = 13;

    localparam logic [POS_WIDTH-1:0]         FINAL_POS  = POS_WIDTH'(STORE_DEPTH);
    localparam logic [7:0]                   HEADER_BYTE = 8'h0F;
    localparam logic signed [CALC_WIDTH-1:0] RAW_OFFSET = 13'sd1000;
    localparam logic [CHAN_WIDTH-1:0]        LAST_CHAN  = CHAN_WIDTH'(NUM_CHANNELS - 1);

    // configuration port
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLAMP_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INVERT_MASK = 1'b1;
    localparam logic [RAW_WIDTH-1:0]       CLAMP_RESET     = 11'd800;
    localparam logic [NUM_CHANNELS-1:0]    INVERT_RESET    = 16'h0004;

    // result item tdata: channel_index, channel_value, status_flags
    localparam int OUT_DATA_WIDTH = CHAN_WIDTH + VALUE_WIDTH + 8;

    typedef struct packed {
        logic                     valid;
        logic [PAYLOAD_WIDTH-1:0] payload;
        logic [7:0]               flags;
    } frame_load_t;

endpackage

@@ rtl/sfd_collector.sv @@
// byte counter and frame store; hands a completed good frame to the channel unit
// depends on sfd_pkg
module sfd_collector (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  logic [7:0]          byte_data,
    input  logic                unit_busy,
    output sfd_pkg::frame_load_t load
);
    import sfd_pkg::*;

    logic [POS_WIDTH-1:0] byte_position_reg;
    logic [POS_WIDTH-1:0] byte_position_next;
    logic [7:0]           frame_store_reg [STORE_DEPTH];
    logic                 at_final;
    logic                 accept;

    // positions past the store count as the end byte
    assign at_final   = (byte_position_reg >= FINAL_POS);
    // the end byte waits while the previous frame is still being sent
    assign byte_ready = !(at_final && unit_busy);
    assign accept     = byte_valid && byte_ready;

    always_comb begin
        byte_position_next = byte_position_reg;
        if (accept) begin
            if (at_final) begin
                byte_position_next = '0;
            end else begin
                byte_position_next = byte_position_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= '0;
        end else begin
            byte_position_reg <= byte_position_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !at_final) begin
            frame_store_reg[byte_position_reg[POS_WIDTH-1:0]] <= byte_data;
        end
    end

    always_comb begin
        load.valid = accept && at_final && (frame_store_reg[0] == HEADER_BYTE);
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            load.payload[i*8 +: 8] = frame_store_reg[i+1];
        end
        load.flags = frame_store_reg[FLAGS_INDEX];
    end

endmodule

@@ rtl/sfd_channel_unit.sv @@
// unpacks the sixteen 11-bit channels one per cycle, unless the output stalls, into the result register
// depends on sfd_pkg; loaded from sfd_collector
module sfd_channel_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sfd_pkg::frame_load_t          load,
    output logic                          busy,
    input  logic [sfd_pkg::RAW_WIDTH-1:0] clamp_limit,
    input  logic [sfd_pkg::NUM_CHANNELS-1:0] invert_mask,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sfd_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
    output logic                          m_tlast
);
    import sfd_pkg::*;

    logic                     busy_reg;
    logic [CHAN_WIDTH-1:0]    chan_reg;
    logic [PAYLOAD_WIDTH-1:0] raw_reg;
    logic [7:0]               flags_reg;

    logic                     out_valid_reg;
    logic [CHAN_WIDTH-1:0]    out_index_reg;
    logic [VALUE_WIDTH-1:0]   out_value_reg;
    logic [7:0]               out_flags_reg;
    logic                     out_last_reg;

    logic                     advance;
    logic signed [CALC_WIDTH-1:0] value_off;
    logic signed [CALC_WIDTH-1:0] value_sgn;
    logic signed [CALC_WIDTH-1:0] lim_pos;
    logic signed [CALC_WIDTH-1:0] lim_neg;
    logic signed [CALC_WIDTH-1:0] value_clamped;

    assign busy    = busy_reg;
    assign advance = busy_reg && (!out_valid_reg || m_tready);

    always_comb begin
        value_off = $signed({2'b00, raw_reg[RAW_WIDTH-1:0]}) - RAW_OFFSET;
        value_sgn = invert_mask[chan_reg] ? -value_off : value_off;
        lim_pos   = $signed({2'b00, clamp_limit});
        lim_neg   = -lim_pos;
        value_clamped = value_sgn;
        if (value_sgn > lim_pos) begin
            value_clamped = lim_pos;
        end else if (value_sgn < lim_neg) begin
            value_clamped = lim_neg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            chan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load.valid) begin
                busy_reg <= 1'b1;
                chan_reg <= '0;
            end else if (advance) begin
                chan_reg <= chan_reg + 1'b1;
                if (chan_reg == LAST_CHAN) begin
                    busy_reg <= 1'b0;
                end
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load.valid) begin
            raw_reg   <= load.payload;
            flags_reg <= load.flags;
        end else if (advance) begin
            raw_reg <= raw_reg >> RAW_WIDTH;
        end
        if (advance) begin
            out_index_reg <= chan_reg;
            out_value_reg <= value_clamped[VALUE_WIDTH-1:0];
            out_flags_reg <= flags_reg;
            out_last_reg  <= (chan_reg == LAST_CHAN);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_flags_reg, out_value_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/sbus_frame_decoder_core.sv @@
// top level of the serial-bus frame decoder: configuration registers and wiring
// depends on sfd_pkg, sfd_collector and sfd_channel_unit
//
// Use: received serial bytes enter on the s_ channel, one byte per item. The
// block counts them into 25-byte frames. When the 25th (end) byte arrives and
// byte 0 is 0x0F, sixteen result items leave on the m_ channel, one per
// channel in order 0..15, with m_tlast on channel 15; a bad header drops the
// frame with no results. Each value is raw - 1000, negated where invert_mask
// has the channel's bit set, then clamped to +/- clamp_limit.
// Output: the accepted end byte loads the channel unit, whose results are then
// registered in the result register and go out one per cycle while m_tready is
// high, set by the single shared channel unpacker.
// Throughput: a byte is accepted every cycle; only the end byte of a frame is
// held off (s_tready low) while the previous frame is still being sent.
// Stall: with m_tready low a held result stays put and unpacking pauses.
// Reset: counter back to the frame start, output empty, clamp_limit 800,
// invert_mask 0x0004. Config writes via cfg_* are always ready.
module sbus_frame_decoder_core (
    input  logic aclk,
    input  logic aresetn,
    // rx_byte [7:0]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    // channel_index [3:0], channel_value [15:4], status_flags [23:16]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [sfd_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [sfd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [sfd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import sfd_pkg::*;

    logic [RAW_WIDTH-1:0]    clamp_limit_reg;
    logic [NUM_CHANNELS-1:0] invert_mask_reg;
    frame_load_t             load;
    logic                    unit_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clamp_limit_reg <= CLAMP_RESET;
            invert_mask_reg <= INVERT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CLAMP_LIMIT: clamp_limit_reg <= cfg_data[RAW_WIDTH-1:0];
                CFG_INVERT_MASK: invert_mask_reg <= cfg_data[NUM_CHANNELS-1:0];
                default: ;
            endcase
        end
    end

    sfd_collector u_collector (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid),
        .byte_ready (s_tready),
        .byte_data  (s_tdata),
        .unit_busy  (unit_busy),
        .load       (load)
    );

    sfd_channel_unit u_channel_unit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .busy        (unit_busy),
        .clamp_limit (clamp_limit_reg),
        .invert_mask (invert_mask_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

@@ tb/sv/sbus_frame_decoder_core_tb.sv @@
// self-checking testbench for sbus_frame_decoder_core: frame streams in, channel items out
// depends on sfd_pkg and the decoder rtl; holds its own decoder model in a scoreboard class
module sbus_frame_decoder_core_tb;
    import sfd_pkg::*;

    localparam int PAYLOAD_BITS = NUM_CHANNELS * RAW_WIDTH;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_SHOWN = 10;

    typedef enum int {FRAME_GOOD, FRAME_BAD_HEADER, FRAME_NOISE} frame_kind_t;

    typedef struct packed {
        logic [CHAN_WIDTH-1:0]  chan_idx;
        logic [VALUE_WIDTH-1:0] value;
        logic [7:0]             flags;
        logic                   last;
    } chan_result_t;

    class channel_scoreboard;
        logic [POS_WIDTH-1:0] byte_pos;
        logic [7:0]           frame_bytes [STORE_DEPTH];
        logic [RAW_WIDTH-1:0] clamp_limit;
        logic [15:0]          invert_mask;
        chan_result_t         pending_channels [$];
        int                   mismatches;
        int                   checked;

        function new();
            byte_pos    = '0;
            clamp_limit = CLAMP_RESET;
            invert_mask = INVERT_RESET;
            mismatches  = 0;
            checked     = 0;
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] data);
            if (idx == CFG_CLAMP_LIMIT)
                clamp_limit = data[RAW_WIDTH-1:0];
            else if (idx == CFG_INVERT_MASK)
                invert_mask = data;
        endfunction

        // one accepted rx item; the end byte of a good frame queues sixteen channels
        function void take_rx_byte(logic [7:0] b);
            logic [PAYLOAD_BITS-1:0] payload;
            chan_result_t            res;
            int                      v;
            int                      lim;
            if (byte_pos < STORE_DEPTH) begin
                frame_bytes[byte_pos] = b;
                byte_pos = byte_pos + 1'b1;
                return;
            end
            byte_pos = '0;
            if (frame_bytes[0] != HEADER_BYTE)
                return;
            lim = int'(clamp_limit);
            for (int i = 0; i < PAYLOAD_BYTES; i++)
                payload[8*i +: 8] = frame_bytes[1+i];
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                v = int'(payload[RAW_WIDTH*k +: RAW_WIDTH]) - 1000;
                if (invert_mask[k])
                    v = -v;
                if (v > lim)
                    v = lim;
                if (v < -lim)
                    v = -lim;
                res.chan_idx = CHAN_WIDTH'(k);
                res.value    = VALUE_WIDTH'(v);
                res.flags    = frame_bytes[FLAGS_INDEX];
                res.last     = (k == NUM_CHANNELS - 1);
                pending_channels.push_back(res);
            end
        endfunction

        function void check_channel(logic [OUT_DATA_WIDTH-1:0] data, logic last);
            chan_result_t got;
            chan_result_t want;
            got.chan_idx = data[3:0];
            got.value    = data[15:4];
            got.flags    = data[23:16];
            got.last     = last;
            checked++;
            if (pending_channels.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected item: ch %0d value %0d flags %02h last %0b",
                             got.chan_idx, $signed(got.value), got.flags, got.last);
                return;
            end
            want = pending_channels.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display({"mismatch: want ch %0d val %0d flags %02h last %0b,",
                              " got ch %0d val %0d flags %02h last %0b"},
                             want.chan_idx, $signed(want.value), want.flags, want.last,
                             got.chan_idx, $signed(got.value), got.flags, got.last);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    channel_scoreboard sb;
    bit no_idle = 1'b0;
    int stall_left = 0;
    int stall_len;
    int bytes_sent = 0;
    int frames_sent = 0;
    int good_frames = 0;
    int settings_used = 1;
    int directed_raw [NUM_CHANNELS] = '{0, 2047, 0, 2047, 1000, 1800, 200, 1801,
                                         199, 1799, 201, 999, 1001, 1, 2046, 1047};

    sbus_frame_decoder_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // raw values at the 11-bit range ends, at 1000, near the clamp edges or at random
    function automatic logic [RAW_WIDTH-1:0] pick_raw();
        int lim;
        int r;
        lim = int'(sb.clamp_limit);
        case ($urandom_range(0, 7))
            0: r = 0;
            1: r = 2047;
            2: r = 1000;
            3: r = 1000 + lim + $urandom_range(0, 2) - 1;
            4: r = 1000 - lim + $urandom_range(0, 2) - 1;
            default: r = $urandom_range(0, 2047);
        endcase
        if (r < 0)
            r = 0;
        if (r > 2047)
            r = 2047;
        return RAW_WIDTH'(r);
    endfunction

    function automatic logic [PAYLOAD_BITS-1:0] random_payload();
        logic [PAYLOAD_BITS-1:0] p;
        for (int k = 0; k < NUM_CHANNELS; k++)
            p[RAW_WIDTH*k +: RAW_WIDTH] = pick_raw();
        return p;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            sb.check_channel(m_tdata, m_tlast);
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            stall_len = pick_gap();
            if (stall_len > 0) begin
                m_tready <= 1'b0;
                stall_left = stall_len - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.take_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_kind_t kind, input logic [PAYLOAD_BITS-1:0] payload,
                              input logic [7:0] flags);
        logic [7:0] fb [FRAME_LENGTH];
        fb[0] = HEADER_BYTE;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            fb[1+i] = payload[8*i +: 8];
        fb[FLAGS_INDEX] = flags;
        fb[FRAME_LENGTH-1] = 8'($urandom_range(0, 255));
        if (kind == FRAME_BAD_HEADER)
            fb[0] = HEADER_BYTE ^ 8'($urandom_range(1, 255));
        else if (kind == FRAME_NOISE)
            foreach (fb[i]) fb[i] = 8'($urandom_range(0, 255));
        if (fb[0] == HEADER_BYTE)
            good_frames++;
        frames_sent++;
        foreach (fb[i]) send_byte(fb[i]);
    endtask

    task automatic set_config(input logic [15:0] clamp_data, input logic [15:0] mask);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CLAMP_LIMIT;
        cfg_data  <= clamp_data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(CFG_CLAMP_LIMIT, clamp_data);
        cfg_index <= CFG_INVERT_MASK;
        cfg_data  <= mask;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(CFG_INVERT_MASK, mask);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // hold the sender off until every queued channel has left, then let the pipe settle
    task automatic drain_results();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.pending_channels.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [PAYLOAD_BITS-1:0] p;
        int r;
        frame_kind_t kind;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: range extremes around the reset clamp, a bad header, all-ones payload
        for (int k = 0; k < NUM_CHANNELS; k++)
            p[RAW_WIDTH*k +: RAW_WIDTH] = RAW_WIDTH'(directed_raw[k]);
        send_frame(FRAME_GOOD, p, 8'hFF);
        send_frame(FRAME_BAD_HEADER, random_payload(), 8'h00);
        send_frame(FRAME_GOOD, '1, 8'h00);
        drain_results();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_config(16'd0, 16'($urandom_range(0, 65535)));
                1: set_config(16'd1047, 16'hFFFF);
                2: set_config(16'hFFFF, 16'h0000);
                3: set_config(16'($urandom_range(0, 1047)), 16'($urandom_range(0, 65535)));
                default: set_config(16'(CLAMP_RESET), 16'(INVERT_RESET));
            endcase
            no_idle = (phase == 2);
            // two frames in one setting, one frame in the others
            for (int f = 0; f < ((phase == 1) ? 2 : 1); f++) begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    kind = FRAME_GOOD;
                else if (r < 88)
                    kind = FRAME_BAD_HEADER;
                else
                    kind = FRAME_NOISE;
                send_frame(kind, random_payload(), 8'($urandom_range(0, 255)));
                if (phase == 1 && f == 0)
                    drain_results();
            end
            drain_results();
        end
        no_idle = 1'b0;

        if (sb.pending_channels.size() != 0) begin
            $display("%0d channel items never arrived", sb.pending_channels.size());
            sb.mismatches += sb.pending_channels.size();
        end
        $display("sent %0d bytes in %0d frames (%0d with a good header) over %0d settings",
                 bytes_sent, frames_sent, good_frames, settings_used);
        $display("checked %0d channel items, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
